// ===== hw/rtl/pt64_pkg.sv =====
// Shared constants, types and the controller state enum for the 64-bit primality tester.
// No dependencies; every other file but the result interface imports this package.
`timescale 1ns / 1ps

package pt64_pkg;

    localparam int unsigned W         = 64;
    localparam int unsigned CNT_W     = $clog2(W);
    localparam int unsigned BITS_W    = $clog2(W + 1);
    localparam int unsigned NUM_BASES = 7;
    localparam int unsigned K_W       = $clog2(NUM_BASES);

    typedef logic [W-1:0] t_word;

    // Fixed Miller-Rabin witness set, exact over all 64-bit values
    localparam t_word BASES [NUM_BASES] = '{
        t_word'(2), t_word'(325), t_word'(9375), t_word'(28178),
        t_word'(450775), t_word'(9780504), t_word'(1795265022)
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD3,
        ST_CLASS,
        ST_SPLIT,
        ST_NORM,
        ST_BASE,
        ST_BASE_WT,
        ST_SQR,
        ST_SQR_WT,
        ST_MULA,
        ST_MULA_WT,
        ST_CHECK,
        ST_LOOP,
        ST_LOOP_WT,
        ST_NEXT,
        ST_DONE
    } t_state;

endpackage

// ===== hw/rtl/pt64_stream_if.sv =====
// Valid/ready channel interfaces for the candidate input and the verdict output.
// Depends on pt64_pkg for the word type.
`timescale 1ns / 1ps

interface pt64_cand_if;
    import pt64_pkg::*;
    logic  valid;
    logic  ready;
    t_word candidate;
    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface pt64_res_if;
    logic valid;
    logic ready;
    logic is_prime;
    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

// ===== hw/rtl/pt64_mulmod.sv =====
// Bit-serial modular multiplier: (a * b) mod m by double-and-add over the bits of b.
// Depends on pt64_pkg. Requires a < m; one modular add per cycle.
`timescale 1ns / 1ps

module pt64_mulmod import pt64_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_op_a,
    input  t_word i_op_b,
    input  t_word i_mod,
    output logic  o_busy,
    output logic  o_done,
    output t_word o_result
);

    logic             r_busy, n_busy;
    logic             r_phase, n_phase;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_word            r_acc, n_acc;
    t_word            r_a, n_a;
    t_word            r_b, n_b;
    t_word            r_m, n_m;

    t_word addend;
    t_word room;
    t_word sum_mod;

    // (acc + addend) mod m without leaving 64 bits; addend is acc when doubling
    always_comb begin
        addend  = r_phase ? r_a : r_acc;
        room    = r_m - addend;
        sum_mod = (r_acc >= room) ? (r_acc - room) : (r_acc + addend);
    end

    // Sequencer: double phase per bit, then an add phase only when the bit is set
    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_a     = r_a;
        n_b     = r_b;
        n_m     = r_m;
        if (i_start && !r_busy) begin
            n_busy  = 1'b1;
            n_phase = 1'b0;
            n_cnt   = CNT_W'(W - 1);
            n_acc   = '0;
            n_a     = i_op_a;
            n_b     = i_op_b;
            n_m     = i_mod;
        end else if (r_busy) begin
            n_acc = sum_mod;
            if (!r_phase && r_b[W-1]) begin
                n_phase = 1'b1;
            end else begin
                n_phase = 1'b0;
                n_b     = {r_b[W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_m   <= n_m;
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_acc;

    // Add phase only ever follows a set multiplier bit
    a_add_on_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_phase && n_phase) |-> r_b[W-1])
        else $error("add phase without a set bit");

    // Done pulses exactly once as the unit goes idle
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("done without finishing");

    // A start is never dropped on a busy unit by the controller
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("start while busy");

endmodule

// ===== hw/rtl/primality_test_64bit.sv =====
// Top level of the 64-bit deterministic Miller-Rabin primality tester.
// Depends on pt64_pkg, pt64_stream_if and pt64_mulmod.
`timescale 1ns / 1ps
//
// Usage
//   i_cand carries one 64-bit candidate per item; o_res returns one is_prime
//   bit per item, in order. i_cand.ready is high only while the controller is
//   idle, so one candidate is worked on at a time.
// Operation
//   Residue mod 3 is found one bit per cycle; even numbers and multiples of
//   3 finish as soon as it is known. Other values strip the trailing zeros
//   of n-1 and left-align it, then run seven bases. Each modular product
//   uses the shared bit-serial multiplier. Each base costs up to about 128
//   products, so a prime near 2^64 takes longest; smaller values and
//   composites finish sooner.
// Reset
//   Synchronous active-low reset returns the controller to idle and empties
//   the output register.
// Stall
//   The verdict waits in the output register until taken; a new candidate is
//   accepted meanwhile, and a finished verdict waits until the register frees.

module primality_test_64bit import pt64_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pt64_cand_if.sink      i_cand,
    pt64_res_if.source     o_res
);

    t_state              r_state, n_state;
    t_word               r_n, n_n;
    t_word               r_sh, n_sh;
    t_word               r_d, n_d;
    t_word               r_a, n_a;
    t_word               r_x, n_x;
    logic [1:0]          r_r3, n_r3;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CNT_W-1:0]    r_s, n_s;
    logic [CNT_W-1:0]    r_r, n_r;
    logic [BITS_W-1:0]   r_dbits, n_dbits;
    logic [BITS_W-1:0]   r_ebits, n_ebits;
    logic [K_W-1:0]      r_k, n_k;
    logic                r_verdict, n_verdict;
    logic                r_out_valid, n_out_valid;
    logic                r_out_bit, n_out_bit;

    logic                mul_start;
    t_word               mul_a, mul_b;
    logic                mul_busy, mul_done;
    t_word               mul_res;
    logic [2:0]          r3_ext;
    t_word               n_minus1;

    assign n_minus1 = r_n - 1'b1;
    assign r3_ext   = {r_r3, r_sh[W-1]};

    pt64_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_op_a   (mul_a),
        .i_op_b   (mul_b),
        .i_mod    (r_n),
        .o_busy   (mul_busy),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_cand.valid) n_state = ST_MOD3;
            ST_MOD3:    if (r_cnt == '0) n_state = ST_CLASS;
            ST_CLASS: begin
                if (r_n < t_word'(2) || !r_n[0] || r_r3 == 2'd0) n_state = ST_DONE;
                else n_state = ST_SPLIT;
            end
            ST_SPLIT:   if (r_sh[0]) n_state = ST_NORM;
            ST_NORM:    if (r_d[W-1]) n_state = ST_BASE;
            ST_BASE:    n_state = ST_BASE_WT;
            ST_BASE_WT: begin
                if (mul_done) n_state = (mul_res == '0) ? ST_NEXT : ST_SQR;
            end
            ST_SQR:     n_state = ST_SQR_WT;
            ST_SQR_WT: begin
                if (mul_done) begin
                    if (r_sh[W-1]) n_state = ST_MULA;
                    else if (r_ebits == BITS_W'(1)) n_state = ST_CHECK;
                    else n_state = ST_SQR;
                end
            end
            ST_MULA:    n_state = ST_MULA_WT;
            ST_MULA_WT: begin
                if (mul_done) n_state = (r_ebits == BITS_W'(1)) ? ST_CHECK : ST_SQR;
            end
            ST_CHECK: begin
                n_state = (r_x == t_word'(1) || r_x == n_minus1) ? ST_NEXT : ST_LOOP;
            end
            ST_LOOP:    n_state = (r_r < r_s) ? ST_LOOP_WT : ST_DONE;
            ST_LOOP_WT: begin
                if (mul_done) begin
                    if (mul_res == n_minus1) n_state = ST_NEXT;
                    else if (mul_res == t_word'(1)) n_state = ST_DONE;
                    else n_state = ST_LOOP;
                end
            end
            ST_NEXT:    n_state = (r_k == K_W'(NUM_BASES - 1)) ? ST_DONE : ST_BASE;
            ST_DONE:    if (!r_out_valid || o_res.ready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_n         = r_n;
        n_sh        = r_sh;
        n_d         = r_d;
        n_a         = r_a;
        n_x         = r_x;
        n_r3        = r_r3;
        n_cnt       = r_cnt;
        n_s         = r_s;
        n_r         = r_r;
        n_dbits     = r_dbits;
        n_ebits     = r_ebits;
        n_k         = r_k;
        n_verdict   = r_verdict;
        n_out_valid = r_out_valid;
        n_out_bit   = r_out_bit;
        mul_start   = 1'b0;
        mul_a       = r_x;
        mul_b       = r_x;

        if (r_out_valid && o_res.ready) n_out_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_cand.valid) begin
                    n_n   = i_cand.candidate;
                    n_sh  = i_cand.candidate;
                    n_cnt = CNT_W'(W - 1);
                    n_r3  = 2'd0;
                end
            end
            ST_MOD3: begin
                // residue mod 3, one bit per cycle from the top
                n_r3  = (r3_ext >= 3'd3) ? 2'(r3_ext - 3'd3) : r3_ext[1:0];
                n_sh  = {r_sh[W-2:0], 1'b0};
                if (r_cnt != '0) n_cnt = r_cnt - 1'b1;
            end
            ST_CLASS: begin
                if (r_n < t_word'(2)) begin
                    n_verdict = 1'b0;
                end else if (!r_n[0] || r_r3 == 2'd0) begin
                    n_verdict = (r_n == t_word'(2)) || (r_n == t_word'(3));
                end else begin
                    n_sh = n_minus1;
                    n_s  = '0;
                end
            end
            ST_SPLIT: begin
                // strip trailing zeros of n-1: n-1 = d * 2^s
                if (!r_sh[0]) begin
                    n_sh = {1'b0, r_sh[W-1:1]};
                    n_s  = r_s + 1'b1;
                end else begin
                    n_d     = r_sh;
                    n_dbits = BITS_W'(W);
                end
            end
            ST_NORM: begin
                // left-align d so the exponent scan starts at its top set bit
                if (!r_d[W-1]) begin
                    n_d     = {r_d[W-2:0], 1'b0};
                    n_dbits = r_dbits - 1'b1;
                end else begin
                    n_k = '0;
                end
            end
            ST_BASE: begin
                // base mod n as 1 * base through the multiplier
                mul_start = 1'b1;
                mul_a     = t_word'(1);
                mul_b     = BASES[r_k];
            end
            ST_BASE_WT: begin
                if (mul_done) begin
                    n_a     = mul_res;
                    n_x     = t_word'(1);
                    n_sh    = r_d;
                    n_ebits = r_dbits;
                end
            end
            ST_SQR, ST_LOOP_WT: begin
                mul_start = (r_state == ST_SQR);
                if (r_state == ST_LOOP_WT && mul_done) begin
                    n_x = mul_res;
                    if (mul_res != n_minus1 && mul_res == t_word'(1)) n_verdict = 1'b0;
                    n_r = r_r + 1'b1;
                end
            end
            ST_SQR_WT: begin
                if (mul_done) begin
                    n_x = mul_res;
                    if (!r_sh[W-1]) begin
                        n_sh    = {r_sh[W-2:0], 1'b0};
                        n_ebits = r_ebits - 1'b1;
                    end
                end
            end
            ST_MULA: begin
                mul_start = 1'b1;
                mul_a     = r_a;
                mul_b     = r_x;
            end
            ST_MULA_WT: begin
                if (mul_done) begin
                    n_x     = mul_res;
                    n_sh    = {r_sh[W-2:0], 1'b0};
                    n_ebits = r_ebits - 1'b1;
                end
            end
            ST_CHECK: begin
                n_r = CNT_W'(1);
            end
            ST_LOOP: begin
                if (r_r < r_s) mul_start = 1'b1;
                else n_verdict = 1'b0;
            end
            ST_NEXT: begin
                if (r_k == K_W'(NUM_BASES - 1)) n_verdict = 1'b1;
                else n_k = r_k + 1'b1;
            end
            ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = r_verdict;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_n       <= n_n;
        r_sh      <= n_sh;
        r_d       <= n_d;
        r_a       <= n_a;
        r_x       <= n_x;
        r_r3      <= n_r3;
        r_cnt     <= n_cnt;
        r_s       <= n_s;
        r_r       <= n_r;
        r_dbits   <= n_dbits;
        r_ebits   <= n_ebits;
        r_k       <= n_k;
        r_verdict <= n_verdict;
        r_out_bit <= n_out_bit;
    end

    assign i_cand.ready   = (r_state == ST_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.is_prime = r_out_bit;

    // Multiplier is idle whenever the controller is idle
    a_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !mul_busy)
        else $error("multiplier busy while idle");

    // A witness check only sees a fully reduced residue
    a_x_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> (r_x < r_n))
        else $error("residue not reduced");

    // Leaving the done state always loads the output register
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && n_state == ST_IDLE) |=> r_out_valid)
        else $error("verdict lost");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for primality_test_64bit: directed and random candidates
// with a bit-exact primality predictor. Depends on pt64_pkg, pt64_stream_if and the DUT.
`timescale 1ns / 1ps

module tb_top import pt64_pkg::*; ();

    localparam int unsigned STALL_LIMIT = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned RANDOM_ITEMS = 80;

    // Primality predictor and the queue of verdicts still owed by the block
    class verdict_board;
        bit verdicts_owed[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // exact (a * b) mod n through a 128-bit product
        function t_word mul_mod(t_word a, t_word b, t_word n);
            logic [127:0] prod;
            prod = {64'b0, a} * {64'b0, b};
            return t_word'(prod % {64'b0, n});
        endfunction

        function t_word pow_mod(t_word b, t_word e, t_word n);
            t_word acc;
            acc = 1 % n;
            b = b % n;
            while (e != 0) begin
                if (e[0]) acc = mul_mod(acc, b, n);
                b = mul_mod(b, b, n);
                e = e >> 1;
            end
            return acc;
        endfunction

        function bit prime_verdict(t_word n);
            t_word odd_part;
            t_word a;
            t_word x;
            int unsigned twos;
            bit witnessed;
            if (n < 2) return 1'b0;
            if (n % 2 == 0 || n % 3 == 0) return (n == 2 || n == 3);
            odd_part = n - 1;
            twos = 0;
            while (!odd_part[0]) begin
                odd_part = odd_part >> 1;
                twos++;
            end
            for (int k = 0; k < NUM_BASES; k++) begin
                a = BASES[k] % n;
                // base that is a multiple of n is skipped
                if (a == 0) continue;
                x = pow_mod(a, odd_part, n);
                if (x == 1 || x == n - 1) continue;
                witnessed = 1'b1;
                for (int r = 1; r < twos; r++) begin
                    x = mul_mod(x, x, n);
                    if (x == n - 1) begin
                        witnessed = 1'b0;
                        break;
                    end
                    if (x == 1) break;
                end
                if (witnessed) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_candidate(t_word n);
            verdicts_owed.push_back(prime_verdict(n));
        endfunction

        function void check_verdict(bit got);
            bit want;
            if (verdicts_owed.size() == 0) begin
                $error("is_prime: verdict %0b with no candidate pending", got);
                errors++;
                return;
            end
            want = verdicts_owed.pop_front();
            if (want !== got) begin
                $error("is_prime: expected %0b, actual %0b", want, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int unsigned idle_cycles;
    verdict_board board;

    pt64_cand_if cand_if();
    pt64_res_if  res_if();

    primality_test_64bit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cand  (cand_if),
        .o_res   (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Candidate driver: random gap, then hold the item until taken
    bit send_burst;
    task automatic send_candidate(t_word n);
        int unsigned gap;
        if ($urandom_range(0, 7) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            cand_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cand_if.valid     <= 1'b1;
        cand_if.candidate <= n;
        do @(posedge i_clk); while (!cand_if.ready);
        board.note_candidate(n);
    endtask

    // Random candidate, weighted toward the cheap classes to bound run time
    function automatic t_word pick_candidate();
        t_word r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return t_word'($urandom_range(0, 65535));
            5, 6:          return r & ~t_word'(1);
            7:             return r - (r % 3);
            default:       return r;
        endcase
    endfunction

    // Verdict receiver with random stalls
    initial begin
        int unsigned stall;
        bit stall_free;
        res_if.ready = 1'b0;
        stall_free = 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 7) == 0) stall_free = !stall_free;
            stall = stall_free ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            board.check_verdict(res_if.is_prime);
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((cand_if.valid && cand_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        t_word p32;
        board = new();
        send_burst = 1'b0;
        i_rst_n = 1'b0;
        cand_if.valid = 1'b0;
        cand_if.candidate = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        p32 = 64'd4294967291;
        // below two, the small primes, small multiples of 2 and 3
        send_candidate(64'd0);
        send_candidate(64'd1);
        send_candidate(64'd2);
        send_candidate(64'd3);
        send_candidate(64'd4);
        send_candidate(64'd9);
        send_candidate(64'd5);      // base 325 is a multiple of n
        send_candidate(64'd13);     // base 325 is a multiple of n
        send_candidate(64'd25);
        send_candidate(64'd1105);   // Carmichael number
        send_candidate(64'd2047);   // strong pseudoprime to base 2
        send_candidate(64'd3215031751);
        send_candidate(p32 * p32);
        send_candidate(64'hFFFF_FFFF_FFFF_FFFF);
        send_candidate(64'hFFFF_FFFF_FFFF_FFFE);
        send_candidate(64'hFFFF_FFFF_FFFF_FFC5);  // largest 64-bit prime
        send_candidate(64'h1FFF_FFFF_FFFF_FFFF);  // Mersenne prime
        send_candidate(64'h8000_0000_0000_0001);
        send_candidate(64'h5555_5555_5555_5555);
        send_candidate(64'hAAAA_AAAA_AAAA_AAAB);

        for (int i = 0; i < RANDOM_ITEMS; i++) send_candidate(pick_candidate());
        cand_if.valid <= 1'b0;

        while (board.verdicts_owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0 && board.verdicts_owed.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
